// ----- rtl/imadec_pkg.sv -----
package imadec_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int CH_IDX_W = 4;

  localparam logic [6:0] IDX_MAX = 7'd88;
  localparam logic signed [17:0] PRED_HI = 18'sd32767;
  localparam logic signed [17:0] PRED_LO = -18'sd32767;

  localparam logic [1:0] HB_SAMPLE_LO = 2'd0;
  localparam logic [1:0] HB_SAMPLE_HI = 2'd1;
  localparam logic [1:0] HB_STEP_IDX  = 2'd2;

  typedef enum logic {
    REG_CHANNEL_COUNT = 1'b0,
    REG_BLOCKS        = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                hdr;
    logic [CH_IDX_W-1:0] ch;
    logic [1:0]          j;
    logic [10:0]         frame;
    logic                last;
  } pos_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         channel;
    logic [10:0]        frame;
    logic               packet_end;
  } result_t;

  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } dec_t;

  localparam logic [14:0] STEP_TABLE [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
    15'd29794, 15'd32767
  };

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    if (idx > IDX_MAX) begin
      s = STEP_TABLE[IDX_MAX];
    end else begin
      s = STEP_TABLE[idx];
    end
    return s;
  endfunction

  function automatic dec_t decode_nibble(input logic signed [15:0] pred,
                                         input logic [6:0] idx,
                                         input logic [3:0] code);
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] sum;
    logic signed [7:0]  nidx;
    dec_t               r;
    step = step_size(idx);
    diff = 17'(step >> 3);
    if (code[0]) begin
      diff = diff + 17'(step >> 2);
    end
    if (code[1]) begin
      diff = diff + 17'(step >> 1);
    end
    if (code[2]) begin
      diff = diff + 17'(step);
    end
    if (code[3]) begin
      sum = $signed({{2{pred[15]}}, pred}) - $signed({1'b0, diff});
    end else begin
      sum = $signed({{2{pred[15]}}, pred}) + $signed({1'b0, diff});
    end
    if (sum > PRED_HI) begin
      r.pred = PRED_HI[15:0];
    end else if (sum < PRED_LO) begin
      r.pred = PRED_LO[15:0];
    end else begin
      r.pred = sum[15:0];
    end
    if (code[2]) begin
      nidx = $signed({1'b0, idx}) + $signed({5'b0, code[1:0], 1'b0}) + 8'sd2;
    end else begin
      nidx = $signed({1'b0, idx}) - 8'sd1;
    end
    if (nidx < 8'sd0) begin
      r.idx = 7'd0;
    end else if (nidx > $signed({1'b0, IDX_MAX})) begin
      r.idx = IDX_MAX;
    end else begin
      r.idx = nidx[6:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/imadec_pos.sv -----
module imadec_pos #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [7:0]       cfg_wdata,
  input  logic             adv,
  output imadec_pkg::pos_t pos
);
  import imadec_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [3:0]      chan_cnt_r;
  logic [7:0]      blocks_r;
  logic            hdr_r;
  logic [CH_W-1:0] ch_r;
  logic [1:0]      j_r;
  logic [7:0]      blk_r;

  logic [4:0]      cc_m1;
  logic [CH_W-1:0] last_ch;
  logic [7:0]      last_blk;

  always_comb begin
    if (chan_cnt_r == 4'd0) begin
      cc_m1 = 5'd0;
    end else if ({1'b0, chan_cnt_r} > 5'(MAX_CHANNELS)) begin
      cc_m1 = 5'(MAX_CHANNELS - 1);
    end else begin
      cc_m1 = {1'b0, chan_cnt_r} - 5'd1;
    end
  end

  assign last_ch  = CH_W'(cc_m1);
  assign last_blk = (blocks_r == 8'd0) ? 8'd0 : blocks_r - 8'd1;

  assign pos.hdr   = hdr_r;
  assign pos.ch    = CH_IDX_W'(ch_r);
  assign pos.j     = j_r;
  assign pos.frame = {blk_r, j_r, 1'b1};
  assign pos.last  = !hdr_r && (blk_r == last_blk) && (ch_r == last_ch) && (j_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= 4'd1;
      blocks_r   <= 8'd63;
      hdr_r      <= 1'b1;
      ch_r       <= '0;
      j_r        <= 2'd0;
      blk_r      <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_CHANNEL_COUNT) begin
        chan_cnt_r <= cfg_wdata[3:0];
      end else begin
        blocks_r <= cfg_wdata;
      end
      hdr_r <= 1'b1;
      ch_r  <= '0;
      j_r   <= 2'd0;
      blk_r <= 8'd0;
    end else if (adv) begin
      j_r <= j_r + 2'd1;
      if (j_r == 2'd3) begin
        if (ch_r != last_ch) begin
          ch_r <= ch_r + CH_W'(1);
        end else begin
          ch_r <= '0;
          if (hdr_r) begin
            hdr_r <= 1'b0;
            blk_r <= 8'd0;
          end else if (blk_r == last_blk) begin
            hdr_r <= 1'b1;
            blk_r <= 8'd0;
          end else begin
            blk_r <= blk_r + 8'd1;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/imadec_core.sv -----
module imadec_core #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_packet_byte,
  input  imadec_pkg::pos_t    pos,
  output logic                adv,
  input  logic                res_space,
  output logic                res_push,
  output imadec_pkg::result_t res
);
  import imadec_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic               s_valid_r;
  logic [7:0]         s_byte_r;
  pos_t               s_pos_r;
  logic               s_phase_r;
  logic [7:0]         latch_r;
  logic signed [15:0] pred_r [MAX_CHANNELS];
  logic [6:0]         idx_r [MAX_CHANNELS];

  logic            is_data;
  logic            need_out;
  logic            go;
  logic            done;
  logic [CH_W-1:0] ch_i;
  logic [3:0]      code;
  dec_t            dec;

  assign is_data  = !s_pos_r.hdr;
  assign need_out = is_data || (s_pos_r.j == HB_SAMPLE_HI);
  assign go       = s_valid_r && (!need_out || res_space);
  assign done     = go && (!is_data || s_phase_r);
  assign in_ready = !s_valid_r || done;
  assign adv      = in_valid && in_ready;
  assign ch_i     = s_pos_r.ch[CH_W-1:0];
  assign code     = s_phase_r ? s_byte_r[7:4] : s_byte_r[3:0];
  assign dec      = decode_nibble(pred_r[ch_i], idx_r[ch_i], code);
  assign res_push = go && need_out;

  always_comb begin
    res.channel = 3'(s_pos_r.ch);
    if (is_data) begin
      res.sample     = dec.pred;
      res.frame      = s_phase_r ? s_pos_r.frame + 11'd1 : s_pos_r.frame;
      res.packet_end = s_phase_r && s_pos_r.last;
    end else begin
      res.sample     = {s_byte_r, latch_r};
      res.frame      = 11'd0;
      res.packet_end = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      s_phase_r <= 1'b0;
      latch_r   <= 8'd0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pred_r[i] <= 16'sd0;
        idx_r[i]  <= 7'd0;
      end
    end else begin
      if (adv) begin
        s_valid_r <= 1'b1;
        s_byte_r  <= in_packet_byte;
        s_pos_r   <= pos;
      end else if (done) begin
        s_valid_r <= 1'b0;
      end
      if (go) begin
        if (is_data) begin
          pred_r[ch_i] <= dec.pred;
          idx_r[ch_i]  <= dec.idx;
          s_phase_r    <= !s_phase_r;
        end else begin
          case (s_pos_r.j)
            HB_SAMPLE_LO: latch_r <= s_byte_r;
            HB_SAMPLE_HI: pred_r[ch_i] <= {s_byte_r, latch_r};
            HB_STEP_IDX: begin
              idx_r[ch_i] <= ({1'b0, s_byte_r} > {2'b0, IDX_MAX}) ? IDX_MAX : s_byte_r[6:0];
            end
            default: ;
          endcase
        end
      end
    end
  end

endmodule

// ----- rtl/imadec_ofifo.sv -----
module imadec_ofifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  imadec_pkg::result_t din,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output imadec_pkg::result_t dout
);
  import imadec_pkg::*;

  result_t    mem_r [2];
  logic [1:0] count_r;
  logic       wr_r;
  logic       rd_r;
  logic       pop;

  assign space     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign dout      = mem_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      if (push) begin
        mem_r[wr_r] <= din;
        wr_r        <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/ima_adpcm_block_decoder.sv -----
// IMA ADPCM decoder for the interleaved block layout, one packet byte per input beat. Each
// channel's four-byte header yields its initial sample as frame 0; every data byte yields two
// samples, low nibble first. A data byte occupies the decode stage for both of its nibbles,
// one nibble decode and one result per cycle while the output queue has space; a header byte
// leaves the decode stage after a single decode step. Each byte is registered in the decode
// stage and each result in the output queue, and a two-beat output queue lets the input side
// keep running for two results while the consumer stalls. Writing either configuration
// register restarts the packet at header byte 0 and keeps each channel's predictor and step
// index.
module ima_adpcm_block_decoder #(
  parameter int MAX_CHANNELS = imadec_pkg::MAX_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_packet_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic [2:0]         out_channel,
  output logic [10:0]        out_frame,
  output logic               out_packet_end
);
  import imadec_pkg::*;

  pos_t    pos;
  logic    adv;
  logic    res_space;
  logic    res_push;
  result_t res;
  result_t dout;

  imadec_pos #(.MAX_CHANNELS(MAX_CHANNELS)) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .pos       (pos)
  );

  imadec_core #(.MAX_CHANNELS(MAX_CHANNELS)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packet_byte (in_packet_byte),
    .pos            (pos),
    .adv            (adv),
    .res_space      (res_space),
    .res_push       (res_push),
    .res            (res)
  );

  imadec_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .din       (res),
    .space     (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign out_sample     = dout.sample;
  assign out_channel    = dout.channel;
  assign out_frame      = dout.frame;
  assign out_packet_end = dout.packet_end;

endmodule

// ----- rtl/imadec_chk.sv -----
module imadec_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample,
  input logic [2:0]         out_channel,
  input logic [10:0]        out_frame,
  input logic               out_packet_end
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_channel)
      && $stable(out_frame) && $stable(out_packet_end))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Decoded samples saturate symmetrically; only a header sample may be the most negative value.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame != 11'd0) |-> out_sample != 16'sh8000)
    else $error("decoded sample outside saturation range");

  // The packet ends on the high nibble of a data byte, which always has an even frame.
  a_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_end |-> (out_frame[0] == 1'b0) && (out_frame != 11'd0))
    else $error("packet end on a wrong frame");

endmodule

bind ima_adpcm_block_decoder imadec_chk u_imadec_chk (.*);
